>>> src/tprq_pkg.sv
// ============================================================================
// tprq_pkg
// Shared types and constants for the task priority ready queue.
// ============================================================================
`default_nettype none

package tprq_pkg;

    // Queue geometry: the entry_count field width holds counts up to 31.
    localparam int QUEUE_DEPTH = 16;
    localparam int PRIO_LEVELS = 8;

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W   = 8;
    localparam int PRIO_W = 3;
    localparam int OP_W   = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] priority_req;
    } task_req_t;

    typedef struct packed {
        logic              hit;
        logic [ID_W-1:0]   out_task_id;
        logic [PRIO_W-1:0] out_priority;
        logic              empty_res;
        logic [4:0]        entry_count;
        logic              overflow;
    } task_res_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } slot_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        slot_t             wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_WALK,
        ST_PUSH_HEAD,
        ST_PULL_WALK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> src/tprq_slot_ram.sv
// ============================================================================
// tprq_slot_ram
// Slot table: one write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module tprq_slot_ram
    import tprq_pkg::*;
(
    input  wire logic     aclk,
    input  wire ram_req_t ram_req,
    output slot_t         rdata
);

    slot_t mem [QUEUE_DEPTH];
    slot_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (ram_req.we) begin
            mem[ram_req.waddr] <= ram_req.wdata;
        end
        if (ram_req.re) begin
            rdata_reg <= mem[ram_req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/tprq_ctrl.sv
// ============================================================================
// tprq_ctrl
// Sequencer: walks the slot table one entry per cycle to insert or extract.
// ============================================================================
`default_nettype none

module tprq_ctrl
    import tprq_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      req_valid,
    input  wire task_req_t req,
    output logic           req_ready,
    input  wire logic      out_free,
    output logic           res_valid,
    output task_res_t      res,
    output ram_req_t       ram_req,
    input  wire slot_t     ram_rdata
);

    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [PRIO_W-1:0] pr_reg, pr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic              found_reg, found_next;
    logic              hit_reg, hit_next;
    logic [ID_W-1:0]   rid_reg, rid_next;
    logic [PRIO_W-1:0] rpr_reg, rpr_next;
    logic              ovf_reg, ovf_next;

    logic [PRIO_W-1:0] pr_sat;
    logic              match;
    logic              last;

    // Priorities past the last level clamp to it
    assign pr_sat = (int'(req.priority_req) > PRIO_LEVELS - 1) ?
                    PRIO_W'(PRIO_LEVELS - 1) : req.priority_req;

    assign match = (op_reg == OP_POP) || (ram_rdata.id == id_reg);
    assign last  = ((CNT_W'(cur_reg) + CNT_W'(1)) == count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        id_reg    <= id_next;
        pr_reg    <= pr_next;
        cur_reg   <= cur_next;
        found_reg <= found_next;
        hit_reg   <= hit_next;
        rid_reg   <= rid_next;
        rpr_reg   <= rpr_next;
        ovf_reg   <= ovf_next;
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        id_next    = id_reg;
        pr_next    = pr_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        found_next = found_reg;
        hit_next   = hit_reg;
        rid_next   = rid_reg;
        rpr_next   = rpr_reg;
        ovf_next   = ovf_reg;
        ram_req    = '0;
        req_ready  = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    op_next    = req.opcode;
                    id_next    = req.task_id;
                    pr_next    = pr_sat;
                    found_next = 1'b0;
                    hit_next   = 1'b0;
                    rid_next   = '0;
                    rpr_next   = '0;
                    ovf_next   = 1'b0;
                    case (req.opcode)
                        OP_PUSH: begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                                ovf_next   = 1'b1;
                                state_next = ST_DONE;
                            end else if (count_reg == '0) begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = '0;
                                ram_req.wdata = '{id: req.task_id, prio: pr_sat};
                                count_next    = count_reg + CNT_W'(1);
                                state_next    = ST_DONE;
                            end else begin
                                // start at the tail, walk toward the head
                                ram_req.re    = 1'b1;
                                ram_req.raddr = ADDR_W'(count_reg - CNT_W'(1));
                                cur_next      = ADDR_W'(count_reg - CNT_W'(1));
                                state_next    = ST_PUSH_WALK;
                            end
                        end
                        OP_POP, OP_REMOVE: begin
                            if (count_reg == '0) begin
                                state_next = ST_DONE;
                            end else begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = '0;
                                cur_next      = '0;
                                state_next    = ST_PULL_WALK;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_PUSH_WALK: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cur_reg + ADDR_W'(1);
                if (ram_rdata.prio > pr_reg) begin
                    // worse priority: move it back one slot
                    ram_req.wdata = ram_rdata;
                    if (cur_reg == '0) begin
                        state_next = ST_PUSH_HEAD;
                    end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = cur_reg - ADDR_W'(1);
                        cur_next      = cur_reg - ADDR_W'(1);
                    end
                end else begin
                    ram_req.wdata = '{id: id_reg, prio: pr_reg};
                    count_next    = count_reg + CNT_W'(1);
                    state_next    = ST_DONE;
                end
            end

            ST_PUSH_HEAD: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = '{id: id_reg, prio: pr_reg};
                count_next    = count_reg + CNT_W'(1);
                state_next    = ST_DONE;
            end

            ST_PULL_WALK: begin
                if (found_reg) begin
                    // close the gap behind the removed entry
                    ram_req.we    = 1'b1;
                    ram_req.waddr = cur_reg - ADDR_W'(1);
                    ram_req.wdata = ram_rdata;
                end else if (match) begin
                    found_next = 1'b1;
                    hit_next   = 1'b1;
                    rid_next   = ram_rdata.id;
                    rpr_next   = ram_rdata.prio;
                end
                if (last) begin
                    if (found_reg || match) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    state_next = ST_DONE;
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = cur_reg + ADDR_W'(1);
                    cur_next      = cur_reg + ADDR_W'(1);
                end
            end

            ST_DONE: begin
                res_valid = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.hit          = hit_reg;
        res.out_task_id  = rid_reg;
        res.out_priority = rpr_reg;
        res.empty_res    = (count_reg == '0);
        res.entry_count  = 5'(count_reg);
        res.overflow     = ovf_reg;
    end

endmodule

`default_nettype wire

>>> src/task_priority_ready_queue_unit.sv
// ============================================================================
// task_priority_ready_queue_unit
// Sorted ready queue of (task id, priority) entries with push, pop and
// remove-by-id, built as a slot RAM walked by a small sequencer.
// ============================================================================
// Walk: a transaction walks the held entries one slot per cycle through
//   the slot RAM's single read port. Empty-queue pops and removes, pushes
//   into an empty or full queue and unused opcodes skip the walk.
// Throughput: one item at a time; the next is taken once the sequencer is
//   idle, even while the previous result still waits in the output register.
// Reset: aresetn low clears the count, sequencer and output valid; slot
//   contents are left as they are and are never read beyond the count.
`default_nettype none

module task_priority_ready_queue_unit
    import tprq_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    // request channel
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire task_req_t s_data,
    // result channel
    output logic           m_valid,
    input  wire logic      m_ready,
    output task_res_t      m_data
);

    ram_req_t  ram_req;
    slot_t     ram_rdata;
    task_res_t res;
    logic      res_valid;
    logic      out_free;

    logic      m_valid_reg, m_valid_next;
    task_res_t m_data_reg;

    // Result register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    tprq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req       (s_data),
        .req_ready (s_ready),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    tprq_slot_ram u_ram (
        .aclk    (aclk),
        .ram_req (ram_req),
        .rdata   (ram_rdata)
    );

    // Output register: loads a finished transaction, holds it until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_free) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> src/tprq_checker.sv
// ============================================================================
// tprq_checker
// Port-level checks on the result channel of the ready queue.
// ============================================================================
`default_nettype none

module tprq_checker
    import tprq_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire task_res_t m_data
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // No returned entry means zero id and priority
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.out_task_id == '0 && m_data.out_priority == '0)
        else $error("miss carries nonzero entry");

    // Empty flag agrees with the count
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.empty_res == (m_data.entry_count == '0))
        else $error("empty flag disagrees with count");

    // Overflow only on a full queue and never with a hit
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow |->
            !m_data.hit && m_data.entry_count == 5'(QUEUE_DEPTH))
        else $error("overflow flagged on a non-full queue");

    // Count never exceeds the table size
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.entry_count <= 5'(QUEUE_DEPTH))
        else $error("entry count beyond depth");

endmodule

bind task_priority_ready_queue_unit tprq_checker u_tprq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
